// ===== rtl/core/spc_pkg.sv =====
package spc_pkg;

  // Defaults for the top-level parameters
  localparam int SPC_MAX_VERTICES = 16;
  localparam int SPC_COORD_WIDTH  = 16;

  // Width of the coordinate fields on the input channel
  localparam int SPC_IN_COORD_W = 16;

  // Operation codes
  localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [1:0] OP_TEST          = 2'd2;

  // Presence flags carried along the projection chain
  typedef struct packed {
    logic first;
    logic second;
  } spc_has_t;

endpackage

// ===== rtl/core/spc_if.sv =====
interface spc_in_if import spc_pkg::*;;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       operation;
  logic signed [SPC_IN_COORD_W-1:0] vertex_x;
  logic signed [SPC_IN_COORD_W-1:0] vertex_y;

  modport source (output valid, output operation, output vertex_x, output vertex_y,
                  input ready);
  modport sink   (input valid, input operation, input vertex_x, input vertex_y,
                  output ready);
endinterface

interface spc_out_if;
  logic valid;
  logic ready;
  logic overlap;
  logic vertex_overflow;

  modport source (output valid, output overlap, output vertex_overflow, input ready);
  modport sink   (input valid, input overlap, input vertex_overflow, output ready);
endinterface

// ===== rtl/core/spc_cell.sv =====
module spc_cell import spc_pkg::*; #(
  parameter int COORD_WIDTH = SPC_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          wr_first,
  input  logic                          wr_second,
  input  logic signed [COORD_WIDTH-1:0] wr_x,
  input  logic signed [COORD_WIDTH-1:0] wr_y,
  input  logic                          pres_first,
  input  logic                          pres_second,
  input  logic signed [COORD_WIDTH:0]   axis_x,
  input  logic signed [COORD_WIDTH:0]   axis_y,
  input  spc_has_t                      has_in,
  input  logic signed [2*COORD_WIDTH+1:0] lo1_in,
  input  logic signed [2*COORD_WIDTH+1:0] hi1_in,
  input  logic signed [2*COORD_WIDTH+1:0] lo2_in,
  input  logic signed [2*COORD_WIDTH+1:0] hi2_in,
  output spc_has_t                      has_out,
  output logic signed [2*COORD_WIDTH+1:0] lo1_out,
  output logic signed [2*COORD_WIDTH+1:0] hi1_out,
  output logic signed [2*COORD_WIDTH+1:0] lo2_out,
  output logic signed [2*COORD_WIDTH+1:0] hi2_out,
  output logic signed [COORD_WIDTH-1:0] x1_out,
  output logic signed [COORD_WIDTH-1:0] y1_out,
  output logic signed [COORD_WIDTH-1:0] x2_out,
  output logic signed [COORD_WIDTH-1:0] y2_out
);

  localparam int DW = 2*COORD_WIDTH + 2;

  logic signed [COORD_WIDTH-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [DW-1:0] px1_r, py1_r, px2_r, py2_r;
  logic signed [DW-1:0] dot1_r, dot2_r;
  logic signed [DW-1:0] lo1_nxt, hi1_nxt, lo2_nxt, hi2_nxt;
  logic signed [DW-1:0] lo1_r, hi1_r, lo2_r, hi2_r;
  spc_has_t             has_nxt, has_r;

  // fold this cell's projections into the running interval
  always_comb begin
    lo1_nxt = lo1_in;
    hi1_nxt = hi1_in;
    lo2_nxt = lo2_in;
    hi2_nxt = hi2_in;
    has_nxt.first  = has_in.first  | pres_first;
    has_nxt.second = has_in.second | pres_second;
    if (pres_first) begin
      if (!has_in.first || dot1_r < lo1_in) lo1_nxt = dot1_r;
      if (!has_in.first || dot1_r > hi1_in) hi1_nxt = dot1_r;
    end
    if (pres_second) begin
      if (!has_in.second || dot2_r < lo2_in) lo2_nxt = dot2_r;
      if (!has_in.second || dot2_r > hi2_in) hi2_nxt = dot2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_first) begin
      x1_r <= wr_x;
      y1_r <= wr_y;
    end
    if (wr_second) begin
      x2_r <= wr_x;
      y2_r <= wr_y;
    end
    px1_r  <= DW'(x1_r) * DW'(axis_x);
    py1_r  <= DW'(y1_r) * DW'(axis_y);
    px2_r  <= DW'(x2_r) * DW'(axis_x);
    py2_r  <= DW'(y2_r) * DW'(axis_y);
    dot1_r <= px1_r + py1_r;
    dot2_r <= px2_r + py2_r;
    lo1_r  <= lo1_nxt;
    hi1_r  <= hi1_nxt;
    lo2_r  <= lo2_nxt;
    hi2_r  <= hi2_nxt;
    has_r  <= has_nxt;
  end

  assign has_out = has_r;
  assign lo1_out = lo1_r;
  assign hi1_out = hi1_r;
  assign lo2_out = lo2_r;
  assign hi2_out = hi2_r;
  assign x1_out  = x1_r;
  assign y1_out  = y1_r;
  assign x2_out  = x2_r;
  assign y2_out  = y2_r;

endmodule

// ===== rtl/core/polygon_overlap_sat.sv =====
// Channel   Dir  Handshake      Payload
// in_chan   in   valid/ready    operation, vertex_x, vertex_y
// out_chan  out  valid/ready    overlap, vertex_overflow
//
// Test: per edge of both polygons, endpoint fetch, axis, zero check, a wait
// covering the multiply, add and cell chain, then the check. A degenerate edge
// or a separating axis ends the test early.
// Synchronous active-low reset clears counts, flags and the sequencer only.
// A test item is held off while a result waits on out_chan; appends go on.
module polygon_overlap_sat import spc_pkg::*; #(
  parameter int MAX_VERTICES = SPC_MAX_VERTICES,
  parameter int COORD_WIDTH  = SPC_COORD_WIDTH
) (
  input logic      clk,
  input logic      rst_n,
  spc_in_if.sink   in_chan,
  spc_out_if.source out_chan
);

  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int AW   = COORD_WIDTH + 1;
  localparam int DW   = 2*COORD_WIDTH + 2;
  localparam int LAT  = MAX_VERTICES + 4;   // wait bound
  localparam int WTW  = $clog2(LAT + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_NEXT, S_FETCH_A, S_FETCH_B, S_ZERO, S_WAIT, S_CHECK
  } state_t;

  state_t                    state_r;
  logic [CNTW-1:0]           cnt1_r, cnt2_r, idx_r;
  logic                      drop_r, pass_r;
  logic signed [COORD_WIDTH-1:0] va_x_r, va_y_r;
  logic signed [AW-1:0]      ax_r, ay_r;
  logic [WTW-1:0]            wait_r;
  logic                      out_valid_r, overlap_r, overflow_r;

  logic                      accept;
  logic [1:0]                op;
  logic signed [31:0]        ext_x, ext_y;
  logic signed [COORD_WIDTH-1:0] coord_x, coord_y;
  logic                      wr1, wr2;

  logic [CNTW-1:0]           n_src, idx_inc, b_idx;
  logic [IW-1:0]             rd_idx;
  logic signed [COORD_WIDTH-1:0] rd_x, rd_y;
  logic                      separated;

  logic signed [COORD_WIDTH-1:0] v1x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] v1y [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] v2x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] v2y [MAX_VERTICES];
  logic signed [DW-1:0] lo1_c [MAX_VERTICES+1];
  logic signed [DW-1:0] hi1_c [MAX_VERTICES+1];
  logic signed [DW-1:0] lo2_c [MAX_VERTICES+1];
  logic signed [DW-1:0] hi2_c [MAX_VERTICES+1];
  spc_has_t             has_c [MAX_VERTICES+1];

  // appends pass a waiting result; a test needs the output register free
  assign in_chan.ready = (state_r == S_IDLE) &&
                         (!out_valid_r || (in_chan.operation != OP_TEST));
  assign accept = in_chan.valid && in_chan.ready;
  assign op     = in_chan.operation;

  // sign-extend the 16-bit field, then wrap to the stored width
  assign ext_x   = 32'(in_chan.vertex_x);
  assign ext_y   = 32'(in_chan.vertex_y);
  assign coord_x = ext_x[COORD_WIDTH-1:0];
  assign coord_y = ext_y[COORD_WIDTH-1:0];

  assign wr1 = accept && (op == OP_APPEND_FIRST)  && (cnt1_r < CNTW'(MAX_VERTICES));
  assign wr2 = accept && (op == OP_APPEND_SECOND) && (cnt2_r < CNTW'(MAX_VERTICES));

  // chain seed: empty intervals
  assign has_c[0] = '0;
  assign lo1_c[0] = '0;
  assign hi1_c[0] = '0;
  assign lo2_c[0] = '0;
  assign hi2_c[0] = '0;

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    spc_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
      .clk        (clk),
      .wr_first   (wr1 && (cnt1_r == CNTW'(i))),
      .wr_second  (wr2 && (cnt2_r == CNTW'(i))),
      .wr_x       (coord_x),
      .wr_y       (coord_y),
      .pres_first (CNTW'(i) < cnt1_r),
      .pres_second(CNTW'(i) < cnt2_r),
      .axis_x     (ax_r),
      .axis_y     (ay_r),
      .has_in     (has_c[i]),
      .lo1_in     (lo1_c[i]),
      .hi1_in     (hi1_c[i]),
      .lo2_in     (lo2_c[i]),
      .hi2_in     (hi2_c[i]),
      .has_out    (has_c[i+1]),
      .lo1_out    (lo1_c[i+1]),
      .hi1_out    (hi1_c[i+1]),
      .lo2_out    (lo2_c[i+1]),
      .hi2_out    (hi2_c[i+1]),
      .x1_out     (v1x[i]),
      .y1_out     (v1y[i]),
      .x2_out     (v2x[i]),
      .y2_out     (v2y[i])
    );
  end

  // edge endpoints: one vertex read per cycle, start then end
  assign n_src   = pass_r ? cnt2_r : cnt1_r;
  assign idx_inc = idx_r + CNTW'(1);
  assign b_idx   = (idx_inc == n_src) ? '0 : idx_inc;
  assign rd_idx  = (state_r == S_FETCH_B) ? b_idx[IW-1:0] : idx_r[IW-1:0];
  assign rd_x    = pass_r ? v2x[rd_idx] : v1x[rd_idx];
  assign rd_y    = pass_r ? v2y[rd_idx] : v1y[rd_idx];

  // an empty polygon or disjoint intervals separate
  assign separated = !has_c[MAX_VERTICES].first || !has_c[MAX_VERTICES].second
                  || (hi2_c[MAX_VERTICES] < lo1_c[MAX_VERTICES])
                  || (hi1_c[MAX_VERTICES] < lo2_c[MAX_VERTICES]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt1_r      <= '0;
      cnt2_r      <= '0;
      drop_r      <= 1'b0;
      pass_r      <= 1'b0;
      idx_r       <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_APPEND_FIRST) begin
              if (wr1) cnt1_r <= cnt1_r + CNTW'(1);
              else     drop_r <= 1'b1;
            end else if (op == OP_APPEND_SECOND) begin
              if (wr2) cnt2_r <= cnt2_r + CNTW'(1);
              else     drop_r <= 1'b1;
            end else if (op == OP_TEST) begin
              pass_r  <= 1'b0;
              idx_r   <= '0;
              state_r <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (idx_r == n_src) begin
            if (!pass_r) begin
              pass_r <= 1'b1;
              idx_r  <= '0;
            end else begin
              out_valid_r <= 1'b1;
              overlap_r   <= 1'b1;
              overflow_r  <= drop_r;
              cnt1_r      <= '0;
              cnt2_r      <= '0;
              drop_r      <= 1'b0;
              state_r     <= S_IDLE;
            end
          end else begin
            state_r <= S_FETCH_A;
          end
        end
        S_FETCH_A: begin
          va_x_r  <= rd_x;
          va_y_r  <= rd_y;
          state_r <= S_FETCH_B;
        end
        S_FETCH_B: begin
          // normal (-dy, dx), unnormalised
          ax_r    <= AW'(va_y_r) - AW'(rd_y);
          ay_r    <= AW'(rd_x) - AW'(va_x_r);
          state_r <= S_ZERO;
        end
        S_ZERO: begin
          wait_r <= '0;
          if (ax_r == '0 && ay_r == '0) begin
            // degenerate edge: no overlap
            out_valid_r <= 1'b1;
            overlap_r   <= 1'b0;
            overflow_r  <= drop_r;
            cnt1_r      <= '0;
            cnt2_r      <= '0;
            drop_r      <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          wait_r <= wait_r + WTW'(1);
          if (wait_r == WTW'(LAT)) state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (separated) begin
            out_valid_r <= 1'b1;
            overlap_r   <= 1'b0;
            overflow_r  <= drop_r;
            cnt1_r      <= '0;
            cnt2_r      <= '0;
            drop_r      <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_NEXT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.overlap         = overlap_r;
  assign out_chan.vertex_overflow = overflow_r;

endmodule
